// File: src/sparse_lower_triangular_solve_assert.svh
`ifndef SPARSE_LOWER_TRIANGULAR_SOLVE_ASSERT_SVH
`define SPARSE_LOWER_TRIANGULAR_SOLVE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define SLTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define SLTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/slts_pkg.sv
package slts_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int FRAC_BITS = 16;

  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int COL_W  = 10;
  localparam int IDX_W  = 10;
  localparam int ERR_W  = 3;
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W = $clog2(MAX_ROWS);
  localparam int CMP_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DIV_W  = ACC_W + FRAC_BITS;
  localparam int QUO_W  = VAL_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] OP_ROW_BEGIN = 2'd0;
  localparam logic [1:0] OP_ENTRY     = 2'd1;
  localparam logic [1:0] OP_ROW_END   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_DIAG  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO_DIAG = 3'd2;
  localparam logic [ERR_W-1:0] ERR_SAT      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

  typedef struct packed {
    logic               start;
    logic [ACC_W-1:0]   num;
    logic [VAL_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [QUO_W-1:0]   quot;
    logic               ovf;
  } div_rsp_t;

endpackage

// File: src/slts_in_if.sv
interface slts_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic                                first_row;
  logic signed [slts_pkg::VAL_W-1:0]   rhs_value;
  logic [slts_pkg::COL_W-1:0]          entry_column;
  logic signed [slts_pkg::VAL_W-1:0]   entry_value;

  modport source (output valid, opcode, first_row, rhs_value, entry_column, entry_value,
                  input ready);
  modport sink (input valid, opcode, first_row, rhs_value, entry_column, entry_value,
                output ready);
endinterface

// File: src/slts_out_if.sv
interface slts_out_if;
  logic                                valid;
  logic                                ready;
  logic [slts_pkg::IDX_W-1:0]          row_index;
  logic signed [slts_pkg::VAL_W-1:0]   x_value;
  logic [slts_pkg::ERR_W-1:0]          error_code;

  modport source (output valid, row_index, x_value, error_code, input ready);
  modport sink (input valid, row_index, x_value, error_code, output ready);
endinterface

// File: src/slts_div.sv
module slts_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slts_pkg::div_req_t   req_i,
  output slts_pkg::div_rsp_t   rsp_o
);

  logic [slts_pkg::DIV_W-1:0]  num_q, num_d;
  logic [slts_pkg::VAL_W-1:0]  den_q, den_d;
  logic [slts_pkg::VAL_W:0]    rem_q, rem_d;
  logic [slts_pkg::QUO_W-1:0]  quot_q, quot_d;
  logic                        ovf_q, ovf_d;
  logic [slts_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [slts_pkg::VAL_W:0]    rem_sh;
  logic                        qbit;

  // Restoring division of (num << FRAC_BITS) by den, one quotient bit per cycle.
  // Quotient bits pushed out of the top only mark overflow.
  always_comb begin
    rem_sh = {rem_q[slts_pkg::VAL_W-1:0], num_q[slts_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = {req_i.num, {slts_pkg::FRAC_BITS{1'b0}}};
      den_d  = req_i.den;
      rem_d  = '0;
      quot_d = '0;
      ovf_d  = 1'b0;
      cnt_d  = slts_pkg::DCNT_W'(slts_pkg::DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_d = {quot_q[slts_pkg::QUO_W-2:0], qbit};
      ovf_d  = ovf_q | quot_q[slts_pkg::QUO_W-1];
      num_d  = num_q << 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == slts_pkg::DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    ovf_q  <= ovf_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.ovf  = ovf_q;

endmodule

// File: src/sparse_lower_triangular_solve.sv
// Row begin and other entries: idle state only. Entry below the diagonal: store read, multiply,
// accumulate. Row end with unit, missing or zero diagonal or row overflow: straight to emit;
// otherwise the one-bit-per-cycle divider runs over the 64-bit shifted dividend first.
// A result sits in an output register; further items are taken while it waits.
// Reset (asynchronous, active low) clears the row state, row count and the unit diagonal bit;
// the solution store is not cleared and needs no clearing pass.
`include "sparse_lower_triangular_solve_assert.svh"

module sparse_lower_triangular_solve (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  slts_in_if.sink    in_i,
  slts_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  localparam logic signed [slts_pkg::ACC_W-1:0] ACC_I32_MAX = 48'sd2147483647;
  localparam logic signed [slts_pkg::ACC_W-1:0] ACC_I32_MIN = -48'sd2147483648;
  localparam logic signed [slts_pkg::ACC_W:0]   ACC_MAX_X = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [slts_pkg::ACC_W:0]   ACC_MIN_X = -49'sh0_8000_0000_0000;
  localparam logic signed [slts_pkg::VAL_W-1:0] ONE_Q =
      slts_pkg::VAL_W'(64'd1 << slts_pkg::FRAC_BITS);
  localparam logic signed [slts_pkg::PROD_W-1:0] HALF_Q = (slts_pkg::FRAC_BITS == 0) ?
      '0 : slts_pkg::PROD_W'(64'd1 << (slts_pkg::FRAC_BITS - 1));

  state_e state_q, state_d;
  logic                                diag_one_q;
  logic signed [slts_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic signed [slts_pkg::VAL_W-1:0]   diag_q, diag_d;
  logic                                seen_q, seen_d;
  logic [slts_pkg::ROW_W-1:0]          row_q, row_d;
  logic                                sat_q, sat_d;
  logic                                neg_q, neg_d;
  logic signed [slts_pkg::VAL_W-1:0]   val_q;
  logic signed [slts_pkg::VAL_W-1:0]   rd_q;
  logic signed [slts_pkg::PROD_W-1:0]  prod_q;
  logic signed [slts_pkg::VAL_W-1:0]   res_x_q, res_x_d;
  logic [slts_pkg::ERR_W-1:0]          res_err_q, res_err_d;
  logic                                res_ovf_q, res_ovf_d;
  logic                                out_valid_q;
  logic [slts_pkg::IDX_W-1:0]          out_row_q;
  logic signed [slts_pkg::VAL_W-1:0]   out_x_q;
  logic [slts_pkg::ERR_W-1:0]          out_err_q;
  logic signed [slts_pkg::VAL_W-1:0]   mem_q [slts_pkg::MAX_ROWS];

  slts_pkg::div_req_t div_req;
  slts_pkg::div_rsp_t div_rsp;

  logic                                in_xfer;
  logic                                row_over;
  logic                                rd_en;
  logic                                out_load;
  logic                                store_we;
  logic signed [slts_pkg::VAL_W-1:0]   clamp_x;
  logic                                clamp_sat;
  logic signed [slts_pkg::PROD_W-1:0]  sub_t;
  logic signed [slts_pkg::PROD_W:0]    acc_diff;
  logic signed [slts_pkg::VAL_W-1:0]   div_x;
  logic                                div_sat;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign row_over   = (row_q >= slts_pkg::ROW_W'(slts_pkg::MAX_ROWS));
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign store_we   = out_load && !res_ovf_q;

  always_comb begin
    clamp_sat = 1'b0;
    clamp_x   = slts_pkg::VAL_W'(acc_q);
    if (acc_q > ACC_I32_MAX) begin
      clamp_sat = 1'b1;
      clamp_x   = 32'sh7FFF_FFFF;
    end else if (acc_q < ACC_I32_MIN) begin
      clamp_sat = 1'b1;
      clamp_x   = -32'sh8000_0000;
    end
  end

  // Rounding to nearest with ties upward is an add of one half and a floor shift.
  assign sub_t    = (prod_q + HALF_Q) >>> slts_pkg::FRAC_BITS;
  assign acc_diff = (slts_pkg::PROD_W + 1)'(acc_q) - (slts_pkg::PROD_W + 1)'(sub_t);

  always_comb begin
    div_sat = div_rsp.ovf;
    div_x   = '0;
    if (neg_q) begin
      if (div_rsp.ovf || div_rsp.quot > 33'h0_8000_0000) begin
        div_sat = 1'b1;
        div_x   = -32'sh8000_0000;
      end else begin
        div_x = slts_pkg::VAL_W'(-div_rsp.quot);
      end
    end else begin
      if (div_rsp.ovf || div_rsp.quot > 33'h0_7FFF_FFFF) begin
        div_sat = 1'b1;
        div_x   = 32'sh7FFF_FFFF;
      end else begin
        div_x = slts_pkg::VAL_W'(div_rsp.quot);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    diag_d      = diag_q;
    seen_d      = seen_q;
    row_d       = row_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    res_x_d     = res_x_q;
    res_err_d   = res_err_q;
    res_ovf_d   = res_ovf_q;
    rd_en       = 1'b0;
    div_req.start = 1'b0;
    div_req.num = acc_q[slts_pkg::ACC_W-1] ? slts_pkg::ACC_W'(-acc_q) : acc_q;
    div_req.den = diag_q[slts_pkg::VAL_W-1] ? slts_pkg::VAL_W'(-diag_q) : diag_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_i.opcode)
            slts_pkg::OP_ROW_BEGIN: begin
              if (in_i.first_row) begin
                row_d = '0;
              end
              acc_d  = slts_pkg::ACC_W'(in_i.rhs_value);
              diag_d = ONE_Q;
              seen_d = 1'b0;
              sat_d  = 1'b0;
            end
            slts_pkg::OP_ENTRY: begin
              if (!row_over) begin
                if (slts_pkg::CMP_W'(in_i.entry_column) < slts_pkg::CMP_W'(row_q)) begin
                  rd_en   = 1'b1;
                  state_d = S_MUL;
                end else if (slts_pkg::CMP_W'(in_i.entry_column) ==
                             slts_pkg::CMP_W'(row_q)) begin
                  diag_d = in_i.entry_value;
                  seen_d = 1'b1;
                end
              end
            end
            slts_pkg::OP_ROW_END: begin
              res_ovf_d = row_over;
              state_d   = S_EMIT;
              if (row_over) begin
                res_x_d   = '0;
                res_err_d = slts_pkg::ERR_OVERFLOW;
              end else if (diag_one_q || !seen_q) begin
                res_x_d   = clamp_x;
                res_err_d = !diag_one_q ? slts_pkg::ERR_NO_DIAG :
                            (sat_q || clamp_sat) ? slts_pkg::ERR_SAT : slts_pkg::ERR_OK;
              end else if (diag_q == '0) begin
                res_err_d = slts_pkg::ERR_ZERO_DIAG;
                res_x_d   = (acc_q > 0) ? 32'sh7FFF_FFFF :
                            (acc_q < 0) ? -32'sh8000_0000 : '0;
              end else begin
                neg_d         = acc_q[slts_pkg::ACC_W-1] ^ diag_q[slts_pkg::VAL_W-1];
                div_req.start = 1'b1;
                state_d       = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (acc_diff > (slts_pkg::PROD_W + 1)'(ACC_MAX_X)) begin
          acc_d = ACC_MAX_X[slts_pkg::ACC_W-1:0];
          sat_d = 1'b1;
        end else if (acc_diff < (slts_pkg::PROD_W + 1)'(ACC_MIN_X)) begin
          acc_d = ACC_MIN_X[slts_pkg::ACC_W-1:0];
          sat_d = 1'b1;
        end else begin
          acc_d = acc_diff[slts_pkg::ACC_W-1:0];
        end
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_x_d   = div_x;
          res_err_d = (sat_q || div_sat) ? slts_pkg::ERR_SAT : slts_pkg::ERR_OK;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (!res_ovf_q) begin
            row_d = row_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      diag_one_q  <= 1'b0;
      acc_q       <= '0;
      diag_q      <= ONE_Q;
      seen_q      <= 1'b0;
      row_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        diag_one_q <= cfg_data_i;
      end
      acc_q  <= acc_d;
      diag_q <= diag_d;
      seen_q <= seen_d;
      row_q  <= row_d;
      sat_q  <= sat_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    res_x_q   <= res_x_d;
    res_err_q <= res_err_d;
    res_ovf_q <= res_ovf_d;
    if (in_xfer) begin
      val_q <= in_i.entry_value;
    end
    if (state_q == S_MUL) begin
      prod_q <= val_q * rd_q;
    end
    if (out_load) begin
      out_row_q <= slts_pkg::IDX_W'(row_q);
      out_x_q   <= res_x_q;
      out_err_q <= res_err_q;
    end
  end

  // Solution store: one read port for entries, one write port for row ends.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem_q[slts_pkg::ADDR_W'(row_q)] <= res_x_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[slts_pkg::ADDR_W'(in_i.entry_column)];
    end
  end

  slts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.row_index  = out_row_q;
  assign out_o.x_value    = out_x_q;
  assign out_o.error_code = out_err_q;

  `SLTS_ASSERT_NEXT(a_read_then_mul, rd_en, state_q == S_MUL)
  `SLTS_ASSERT_NOW(a_div_from_idle, div_req.start, state_q == S_IDLE && in_xfer)
  `SLTS_ASSERT_NOW(a_row_bounded, 1'b1, row_q <= slts_pkg::ROW_W'(slts_pkg::MAX_ROWS))
  `SLTS_ASSERT_NOW(a_write_in_range, store_we, row_q < slts_pkg::ROW_W'(slts_pkg::MAX_ROWS))
  `SLTS_ASSERT_NOW(a_done_in_div, div_rsp.done, state_q == S_DIV)

endmodule

// File: test/sparse_lower_triangular_solve_tb.sv
`timescale 1ns / 100ps

module sparse_lower_triangular_solve_tb;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct {
    logic [slts_pkg::IDX_W-1:0]        row;
    logic signed [slts_pkg::VAL_W-1:0] x;
    logic [slts_pkg::ERR_W-1:0]        err;
  } solution_t;

  class slts_scoreboard;
    logic signed [slts_pkg::VAL_W-1:0] x_mem[slts_pkg::MAX_ROWS];
    longint                            acc;
    logic signed [slts_pkg::VAL_W-1:0] diag;
    bit                                diag_seen;
    int unsigned                       cur_row;
    bit                                sat_flag;
    bit                                diag_one;
    solution_t                         pending[$];
    int                                errors;

    function new();
      acc = 0;
      diag = Q_ONE;
      diag_seen = 0;
      cur_row = 0;
      sat_flag = 0;
      diag_one = 0;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function logic signed [slts_pkg::VAL_W-1:0] clamp32(longint v, inout bit sat);
      if (v > longint'(Q_MAX)) begin
        sat = 1;
        return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
        sat = 1;
        return Q_MIN;
      end
      return v[31:0];
    endfunction

    function void note_input(logic [1:0] op, bit fr, logic signed [slts_pkg::VAL_W-1:0] rhs,
                             logic [slts_pkg::COL_W-1:0] col,
                             logic signed [slts_pkg::VAL_W-1:0] val);
      longint prod;
      longint a;
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      longint unsigned r;
      longint unsigned qcap;
      bit sat;
      bit negq;
      solution_t s;
      qcap = 64'd1 << 40;
      case (op)
        slts_pkg::OP_ROW_BEGIN: begin
          if (fr) cur_row = 0;
          acc = longint'(rhs);
          diag = Q_ONE;
          diag_seen = 0;
          sat_flag = 0;
        end
        slts_pkg::OP_ENTRY: begin
          if (cur_row < slts_pkg::MAX_ROWS) begin
            if (col < cur_row) begin
              prod = longint'(val) * longint'(x_mem[col]);
              a = acc - ((prod + (64'sd1 <<< (slts_pkg::FRAC_BITS - 1))) >>>
                         slts_pkg::FRAC_BITS);
              if (a > 64'sh7FFF_FFFF_FFFF) begin
                a = 64'sh7FFF_FFFF_FFFF;
                sat_flag = 1;
              end
              if (a < -64'sh8000_0000_0000) begin
                a = -64'sh8000_0000_0000;
                sat_flag = 1;
              end
              acc = a;
            end else if (col == cur_row) begin
              diag = val;
              diag_seen = 1;
            end
          end
        end
        slts_pkg::OP_ROW_END: begin
          s.row = cur_row[slts_pkg::IDX_W-1:0];
          s.err = slts_pkg::ERR_OK;
          sat = sat_flag;
          if (cur_row >= slts_pkg::MAX_ROWS) begin
            s.x = '0;
            s.err = slts_pkg::ERR_OVERFLOW;
          end else begin
            if (diag_one) begin
              s.x = clamp32(acc, sat);
            end else if (!diag_seen) begin
              s.err = slts_pkg::ERR_NO_DIAG;
              s.x = clamp32(acc, sat);
            end else if (diag == 0) begin
              s.err = slts_pkg::ERR_ZERO_DIAG;
              s.x = (acc > 0) ? Q_MAX : ((acc < 0) ? Q_MIN : 32'sd0);
            end else begin
              negq = (acc < 0) != (diag < 0);
              n = (acc < 0) ? longint'(-acc) : longint'(acc);
              d = (diag < 0) ? -longint'(diag) : longint'(diag);
              q = n / d;
              r = n % d;
              if (q > qcap) q = qcap;
              for (int i = 0; i < slts_pkg::FRAC_BITS; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= d) begin
                  r = r - d;
                  q = q | 1;
                end
                if (q > qcap) q = qcap;
              end
              s.x = clamp32(negq ? -longint'(q) : longint'(q), sat);
            end
            if (s.err == slts_pkg::ERR_OK && sat) s.err = slts_pkg::ERR_SAT;
            x_mem[cur_row] = s.x;
            cur_row++;
          end
          pending.push_back(s);
        end
        default: ;
      endcase
    endfunction

    task check(logic [slts_pkg::IDX_W-1:0] row, logic signed [slts_pkg::VAL_W-1:0] x,
               logic [slts_pkg::ERR_W-1:0] err);
      solution_t s;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result row %0d x %h err %0d", row, x, err));
        return;
      end
      s = pending.pop_front();
      if (row !== s.row) report($sformatf("row_index %0d, wanted %0d", row, s.row));
      if (x !== s.x) report($sformatf("row %0d x_value %h, wanted %h", s.row, x, s.x));
      if (err !== s.err)
        report($sformatf("row %0d error_code %0d, wanted %0d", s.row, err, s.err));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_data;

  slts_in_if  in_bus();
  slts_out_if out_bus();

  sparse_lower_triangular_solve DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  slts_scoreboard sb = new();

  int  cycles = 0;
  int  items_sent = 0;
  bit  no_idle = 0;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  sink_burst = 0;
  bit  sink_stall = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sparse_lower_triangular_solve_tb: errors");
      $finish;
    end
  end

  // Result side: checks each transfer and stalls in random bursts or on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        sb.check(out_bus.row_index, out_bus.x_value, out_bus.error_code);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (no_idle) begin
        out_bus.ready <= 1'b1;
      end else begin
        if (sink_burst == 0) begin
          sink_burst = $urandom_range(1, 16);
          sink_stall = ($urandom_range(0, 2) == 0);
        end
        sink_burst--;
        out_bus.ready <= !sink_stall;
      end
    end
  end

  task automatic send(logic [1:0] op, bit fr, logic signed [31:0] rhs, logic [9:0] col,
                      logic signed [31:0] val);
    in_bus.valid        <= 1'b1;
    in_bus.opcode       <= op;
    in_bus.first_row    <= fr;
    in_bus.rhs_value    <= rhs;
    in_bus.entry_column <= col;
    in_bus.entry_value  <= val;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(op, fr, rhs, col, val);
    items_sent++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_diag_one(bit v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.diag_one = v;
  endtask

  function automatic logic signed [31:0] rand_q(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  // One well-formed row: begin, entries in random order, end.
  task automatic random_row(bit fr);
    int unsigned r;
    int n;
    bit wide;
    logic [9:0] col;
    logic signed [31:0] dv;
    wide = ($urandom_range(0, 7) == 0);
    send(slts_pkg::OP_ROW_BEGIN, fr, rand_q(wide), 10'($urandom), $urandom);
    r = sb.cur_row;
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: col = 10'($urandom_range(0, 1023));
        1: col = r[9:0];
        default: col = (r > 0) ? 10'($urandom_range(0, r - 1)) : r[9:0];
      endcase
      if (col == r[9:0] && r < slts_pkg::MAX_ROWS) begin
        case ($urandom_range(0, 9))
          0: dv = 0;
          1: dv = $urandom;
          default: dv = $signed($urandom_range(1 << 14, 1 << 18)) *
                        (($urandom_range(0, 1) == 1) ? 1 : -1);
        endcase
      end else begin
        dv = rand_q(wide);
      end
      send(slts_pkg::OP_ENTRY, 1'b0, $urandom, col, dv);
    end
    send(slts_pkg::OP_ROW_END, 1'($urandom_range(0, 1)), $urandom, 10'($urandom), $urandom);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.opcode       = slts_pkg::OP_ROW_BEGIN;
    in_bus.first_row    = 1'b0;
    in_bus.rhs_value    = '0;
    in_bus.entry_column = '0;
    in_bus.entry_value  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: plain division, extremes, missing and zero diagonals, saturation.
    send(slts_pkg::OP_ROW_BEGIN, 1'b1, Q_MAX, 10'd0, 32'sd0);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd0, Q_ONE);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, Q_MIN, 10'd0, 32'sd0);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd0, 32'sh0000_8000);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd1023, Q_MAX);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd1, -32'sh0002_0000);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, 32'sh0003_0000, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, 32'sh0001_0000, 10'd0, 32'sd0);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd3, 32'sd0);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, -32'sh0001_0000, 10'd0, 32'sd0);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd4, 32'sd0);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd5, 32'sd0);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, Q_MAX, 10'd0, 32'sd0);
    send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd6, 32'sd1);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    // Row zero holds the largest value, so these products drive the accumulator to its limit.
    send(slts_pkg::OP_ROW_BEGIN, 1'b0, Q_MAX, 10'd0, 32'sd0);
    repeat (3) send(slts_pkg::OP_ENTRY, 1'b0, 32'sd0, 10'd0, Q_MIN);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);
    send(OP_IGNORED, 1'b1, Q_MIN, 10'd1023, Q_MIN);
    send(slts_pkg::OP_ROW_END, 1'b0, 32'sd0, 10'd0, 32'sd0);

    write_diag_one(1'b1);
    random_row(1'b1);
    random_row(1'b0);
    random_row(1'b0);

    write_diag_one(1'b0);
    while (items_sent < 450) begin
      if (items_sent > 120 && items_sent < 130 && hold_seq == 0) hold_seq <= 1;
      if (items_sent > 200 && items_sent < 210 && !sb.diag_one) write_diag_one(1'b1);
      if (items_sent > 290 && items_sent < 300 && sb.diag_one) write_diag_one(1'b0);
      if (items_sent > 370) no_idle = 1;
      if ($urandom_range(0, 6) == 0) begin
        // Noise: a lone item of any kind with any content.
        send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, 10'($urandom),
             $urandom);
      end else begin
        random_row(sb.cur_row >= 10 || $urandom_range(0, 5) == 0);
      end
    end

    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("results still outstanding");
    if (sb.errors == 0) begin
      $display("sparse_lower_triangular_solve_tb: clean");
    end else begin
      $display("sparse_lower_triangular_solve_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/slts_pkg.sv
src/slts_in_if.sv
src/slts_out_if.sv
src/slts_div.sv
src/sparse_lower_triangular_solve.sv
test/sparse_lower_triangular_solve_tb.sv
